// File: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU size-budget cache policy
// Operation and status codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int KeyW   = 32;
	localparam int SizeW  = 32;
	localparam int HitsW  = 32;
	localparam int StampW = 32;
	localparam int PayW   = 64;
	localparam int UsedW  = 40;
	localparam logic [UsedW-1:0] DefaultLimit = 40'd1073741824;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_HIT   = 3'd1,
		OP_HAS   = 3'd2,
		OP_GET   = 3'd3,
		OP_DEL   = 3'd4,
		OP_PEEK  = 3'd5,
		OP_SETPL = 3'd6,
		OP_NONE  = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_PRESENT = 3'd1,
		ST_MISSING = 3'd2,
		ST_NOSTORE = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_EVICT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]      status;
		logic            evicted;
		logic [KeyW-1:0] okey;
		logic [PayW-1:0] opay;
		logic            present;
		logic            last;
	} result_t;

endpackage

// File: rtl/lfu_size_budget_cache_policy.sv
// ----------------------------------------------------------------------------
// lfu_size_budget_cache_policy: keyed object cache with LFU eviction
// Byte-budgeted table of ENTRIES slots, scanned by one shared compare unit.
// ----------------------------------------------------------------------------
// Each operation beat on s_axis is handled by a sequencer that walks the table
// one slot per cycle through a single compare unit: it finds the key, the
// lowest free slot and the victim (fewest hits, then oldest stamp, then
// smallest key) in one pass over the table. An add that must evict reports
// each eviction as its own m_axis beat (tlast low) and rescans after each one.
// s_axis_tready is high only when the sequencer is idle. The result register
// holds one beat until m_axis_tready takes it. The byte budget register is
// written through cfg_valid/cfg_ready and must only be changed while idle.
// ----------------------------------------------------------------------------
module lfu_size_budget_cache_policy #(
	parameter int ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [39:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: key[31:0], obj_bytes[63:32], payload[127:64]
	input  logic [127:0] s_axis_tdata,
	// tuser: kind[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: status[2:0], out_key[34:3], out_payload[98:35], zero fill
	output logic [103:0] m_axis_tdata,
	// tuser: evicted[0], present[1]
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam int IdxW = $clog2(ENTRIES);

	// table storage
	logic [ENTRIES-1:0]               valid_q;
	logic [lfu_pkg::KeyW-1:0]         key_q   [ENTRIES];
	logic [lfu_pkg::SizeW-1:0]        size_q  [ENTRIES];
	logic [lfu_pkg::HitsW-1:0]        hits_q  [ENTRIES];
	logic [lfu_pkg::StampW-1:0]       stamp_q [ENTRIES];
	logic [lfu_pkg::PayW-1:0]         pay_q   [ENTRIES];

	logic [lfu_pkg::UsedW-1:0]        limit_q, used_q;
	logic [lfu_pkg::StampW-1:0]       clock_q;

	// operation latched at accept
	lfu_pkg::op_t                     op_q;
	logic [lfu_pkg::KeyW-1:0]         ikey_q;
	logic [lfu_pkg::SizeW-1:0]        isize_q;
	logic [lfu_pkg::PayW-1:0]         ipay_q;

	// scan results
	logic [IdxW-1:0]                  idx_q;
	logic                             found_q, freef_q, vicf_q;
	logic [IdxW-1:0]                  fidx_q, free_q, vic_q;

	lfu_pkg::state_t                  state_q, state_d;
	lfu_pkg::result_t                 res_q;
	logic                             ovalid_q;

	// final result held from decide time, and the eviction beat
	lfu_pkg::result_t                 fin_q;
	lfu_pkg::result_t                 ev_res;

	// shared compare unit: slot idx_q against the running victim
	logic [IdxW-1:0]                  cur;
	logic                             lower;
	logic                             last_slot;
	assign cur       = idx_q;
	assign last_slot = ({{(32-IdxW){1'b0}}, idx_q} == ENTRIES - 1);
	always_comb begin
		if (hits_q[cur] != hits_q[vic_q])
			lower = hits_q[cur] < hits_q[vic_q];
		else if (stamp_q[cur] != stamp_q[vic_q])
			lower = stamp_q[cur] < stamp_q[vic_q];
		else
			lower = key_q[cur] < key_q[vic_q];
	end

	logic accept_in, take_out, load_out;
	assign accept_in     = s_axis_tvalid && s_axis_tready;
	assign take_out      = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == lfu_pkg::S_IDLE);
	assign cfg_ready     = 1'b1;
	// load the result register once the previous beat has gone
	assign load_out      = ((state_q == lfu_pkg::S_EVICT) || (state_q == lfu_pkg::S_OUT)) &&
		(!ovalid_q || take_out);

	// add decision
	logic [lfu_pkg::UsedW-1:0] sum;
	logic                      over, must_evict, fits;
	assign sum        = used_q + {{(lfu_pkg::UsedW-lfu_pkg::SizeW){1'b0}}, isize_q};
	assign over       = used_q >= limit_q;
	assign must_evict = vicf_q && (over || !freef_q);
	assign fits       = ({1'b0, used_q} + {9'd0, isize_q}) <= {1'b0, limit_q};
	logic [lfu_pkg::UsedW-1:0] used_after_drop;
	logic [IdxW-1:0]           drop_idx;
	assign drop_idx = (state_q == lfu_pkg::S_EVICT) ? vic_q : fidx_q;
	assign used_after_drop = (used_q >= {8'd0, size_q[drop_idx]}) ?
		used_q - {8'd0, size_q[drop_idx]} : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lfu_pkg::S_IDLE:   if (accept_in) state_d = lfu_pkg::S_SCAN;
			lfu_pkg::S_SCAN:   if (last_slot) state_d = lfu_pkg::S_DECIDE;
			lfu_pkg::S_DECIDE: begin
				if (op_q == lfu_pkg::OP_ADD && !found_q && must_evict)
					state_d = lfu_pkg::S_EVICT;
				else
					state_d = lfu_pkg::S_OUT;
			end
			lfu_pkg::S_EVICT:  if (!ovalid_q || take_out) state_d = lfu_pkg::S_SCAN;
			lfu_pkg::S_OUT:    if (!ovalid_q || take_out) state_d = lfu_pkg::S_IDLE;
			default:           state_d = lfu_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lfu_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// final result of the operation, formed in S_DECIDE
	lfu_pkg::result_t fin;
	always_comb begin
		fin      = '0;
		fin.last = 1'b1;
		case (op_q)
			lfu_pkg::OP_ADD:
				if (found_q)
					fin.status = lfu_pkg::ST_PRESENT;
				else if (!(freef_q && fits))
					fin.status = lfu_pkg::ST_NOSTORE;
			lfu_pkg::OP_HIT, lfu_pkg::OP_DEL, lfu_pkg::OP_SETPL:
				if (!found_q) fin.status = lfu_pkg::ST_MISSING;
			lfu_pkg::OP_HAS:   fin.present = found_q;
			lfu_pkg::OP_GET:
				if (!found_q) fin.status = lfu_pkg::ST_MISSING;
				else fin.opay = pay_q[fidx_q];
			lfu_pkg::OP_PEEK:
				if (!vicf_q) fin.status = lfu_pkg::ST_EMPTY;
				else begin
					fin.okey = key_q[vic_q];
					fin.opay = pay_q[vic_q];
				end
			default: fin = fin;
		endcase
	end

	// eviction beat: the current victim, never last
	always_comb begin
		ev_res         = '0;
		ev_res.evicted = 1'b1;
		ev_res.okey    = key_q[vic_q];
		ev_res.opay    = pay_q[vic_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			limit_q  <= lfu_pkg::DefaultLimit;
			used_q   <= '0;
			clock_q  <= '0;
			ovalid_q <= 1'b0;
			res_q    <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			freef_q  <= 1'b0;
			vicf_q   <= 1'b0;
		end else begin
			if (cfg_valid) limit_q <= cfg_data;
			if (load_out) begin
				ovalid_q <= 1'b1;
				res_q    <= (state_q == lfu_pkg::S_EVICT) ? ev_res : fin_q;
			end else if (take_out) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				lfu_pkg::S_IDLE: if (accept_in) begin
					idx_q   <= '0;
					found_q <= 1'b0;
					freef_q <= 1'b0;
					vicf_q  <= 1'b0;
				end
				lfu_pkg::S_SCAN: begin
					// one slot per cycle through the compare unit
					if (valid_q[cur]) begin
						if (key_q[cur] == ikey_q && !found_q) begin
							found_q <= 1'b1;
							fidx_q  <= cur;
						end
						if (!vicf_q || lower) begin
							vicf_q <= 1'b1;
							vic_q  <= cur;
						end
					end else if (!freef_q) begin
						freef_q <= 1'b1;
						free_q  <= cur;
					end
					idx_q <= last_slot ? '0 : idx_q + 1'b1;
				end
				lfu_pkg::S_DECIDE: begin
					if (!(op_q == lfu_pkg::OP_ADD && !found_q && must_evict)) begin
						case (op_q)
							lfu_pkg::OP_ADD: if (!found_q) begin
								clock_q <= clock_q + 1'b1;
								if (freef_q && fits) begin
									valid_q[free_q] <= 1'b1;
									key_q[free_q]   <= ikey_q;
									size_q[free_q]  <= isize_q;
									hits_q[free_q]  <= 32'd1;
									stamp_q[free_q] <= clock_q;
									pay_q[free_q]   <= ipay_q;
									used_q          <= sum;
								end
							end
							lfu_pkg::OP_HIT: if (found_q) begin
								if (hits_q[fidx_q] != '1)
									hits_q[fidx_q] <= hits_q[fidx_q] + 1'b1;
								stamp_q[fidx_q] <= clock_q;
								clock_q         <= clock_q + 1'b1;
							end
							lfu_pkg::OP_DEL: if (found_q) begin
								valid_q[fidx_q] <= 1'b0;
								used_q          <= used_after_drop;
							end
							lfu_pkg::OP_SETPL: if (found_q) pay_q[fidx_q] <= ipay_q;
							default: ;
						endcase
					end
				end
				lfu_pkg::S_EVICT: if (load_out) begin
					// drop the reported victim and rescan
					valid_q[vic_q] <= 1'b0;
					used_q         <= used_after_drop;
					freef_q        <= 1'b0;
					vicf_q         <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// hold the final result computed at decide time
	always_ff @(posedge clk) begin
		if (state_q == lfu_pkg::S_DECIDE) fin_q <= fin;
		if (accept_in) begin
			op_q    <= lfu_pkg::op_t'(s_axis_tuser);
			ikey_q  <= s_axis_tdata[31:0];
			isize_q <= s_axis_tdata[63:32];
			ipay_q  <= s_axis_tdata[127:64];
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {5'd0, res_q.opay, res_q.okey, res_q.status};
	assign m_axis_tuser  = {res_q.present, res_q.evicted};
	assign m_axis_tlast  = res_q.last;

`ifndef ASSERT_OFF
	// no new operation is taken while the sequencer is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lfu_pkg::S_IDLE) |-> !s_axis_tready)
		else $error("accepted beat while busy");
	// an eviction beat is never the last beat of its operation
	a_evlast: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tlast)
		else $error("eviction marked last");
	// a result beat waiting on the consumer keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
`endif

endmodule

// File: tb/tb_lfu_size_budget_cache_policy.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lfu_size_budget_cache_policy: stream test of the LFU size-budget cache
// Drives cache operations on s_axis under random bursts and gaps, predicts
// every result beat (evictions first, then the final beat) with a software
// copy of the cache table, and compares m_axis beats in order under random
// backpressure. The byte budget is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_lfu_size_budget_cache_policy;

	localparam int NSLOT = 16;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]  status;
		logic        evicted;
		logic [31:0] okey;
		logic [63:0] opay;
		logic        present;
		logic        last;
	} beat_t;

	// Software copy of the cache table; predicts the result beats of each op
	// and holds them until the block sends them.
	class cache_scoreboard;
		bit          vld[NSLOT];
		bit [31:0]   keyv[NSLOT];
		bit [31:0]   sz[NSLOT];
		bit [31:0]   hits[NSLOT];
		bit [31:0]   stamp[NSLOT];
		bit [63:0]   hnd[NSLOT];
		bit [39:0]   used;
		bit [31:0]   now;
		bit [39:0]   budget;
		beat_t       pending[$];
		int          errors;

		function new();
			budget = lfu_pkg::DefaultLimit;
		endfunction

		function int find(bit [31:0] k);
			for (int i = 0; i < NSLOT; i++)
				if (vld[i] && keyv[i] == k) return i;
			return -1;
		endfunction

		function int free_slot();
			for (int i = 0; i < NSLOT; i++)
				if (!vld[i]) return i;
			return -1;
		endfunction

		function int victim();
			int v;
			v = -1;
			for (int i = 0; i < NSLOT; i++) begin
				if (!vld[i]) continue;
				if (v < 0 || hits[i] < hits[v] ||
					(hits[i] == hits[v] && (stamp[i] < stamp[v] ||
					(stamp[i] == stamp[v] && keyv[i] < keyv[v]))))
					v = i;
			end
			return v;
		endfunction

		function void push(logic [2:0] st, logic ev, logic [31:0] k, logic [63:0] p,
			logic pr, logic la);
			beat_t b;
			b.status = st; b.evicted = ev; b.okey = k; b.opay = p;
			b.present = pr; b.last = la;
			pending.push_back(b);
		endfunction

		function void remove(int i);
			used = (used >= sz[i]) ? used - sz[i] : 40'd0;
			vld[i] = 0;
		endfunction

		function void evict();
			int v;
			v = victim();
			if (v < 0) return;
			push(lfu_pkg::ST_OK, 1, keyv[v], hnd[v], 0, 0);
			remove(v);
		endfunction

		// Note an accepted op and queue its expected beats.
		function void note_op(lfu_pkg::op_t op, bit [31:0] k, bit [31:0] osz,
			bit [63:0] p);
			int i;
			i = find(k);
			case (op)
				lfu_pkg::OP_ADD: begin
					if (i >= 0) begin
						push(lfu_pkg::ST_PRESENT, 0, 0, 0, 0, 1);
						return;
					end
					while (victim() >= 0 && used >= budget) evict();
					if (free_slot() < 0) evict();
					i = free_slot();
					if (i >= 0 && {1'b0, used} + osz <= {1'b0, budget}) begin
						vld[i] = 1; keyv[i] = k; sz[i] = osz; hits[i] = 1;
						stamp[i] = now; hnd[i] = p; used = used + osz;
						push(lfu_pkg::ST_OK, 0, 0, 0, 0, 1);
					end else
						push(lfu_pkg::ST_NOSTORE, 0, 0, 0, 0, 1);
					now++;
				end
				lfu_pkg::OP_HIT: begin
					if (i < 0) push(lfu_pkg::ST_MISSING, 0, 0, 0, 0, 1);
					else begin
						if (hits[i] != '1) hits[i]++;
						stamp[i] = now;
						now++;
						push(lfu_pkg::ST_OK, 0, 0, 0, 0, 1);
					end
				end
				lfu_pkg::OP_HAS: push(lfu_pkg::ST_OK, 0, 0, 0, i >= 0, 1);
				lfu_pkg::OP_GET: begin
					if (i < 0) push(lfu_pkg::ST_MISSING, 0, 0, 0, 0, 1);
					else push(lfu_pkg::ST_OK, 0, 0, hnd[i], 0, 1);
				end
				lfu_pkg::OP_DEL: begin
					if (i < 0) push(lfu_pkg::ST_MISSING, 0, 0, 0, 0, 1);
					else begin
						remove(i);
						push(lfu_pkg::ST_OK, 0, 0, 0, 0, 1);
					end
				end
				lfu_pkg::OP_PEEK: begin
					i = victim();
					if (i < 0) push(lfu_pkg::ST_EMPTY, 0, 0, 0, 0, 1);
					else push(lfu_pkg::ST_OK, 0, keyv[i], hnd[i], 0, 1);
				end
				lfu_pkg::OP_SETPL: begin
					if (i < 0) push(lfu_pkg::ST_MISSING, 0, 0, 0, 0, 1);
					else begin
						hnd[i] = p;
						push(lfu_pkg::ST_OK, 0, 0, 0, 0, 1);
					end
				end
				default: push(lfu_pkg::ST_OK, 0, 0, 0, 0, 1);
			endcase
		endfunction

		// Compare one result beat with the oldest expectation.
		function void check_beat(beat_t got);
			beat_t w;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: status %0d key %h", got.status, got.okey);
				return;
			end
			w = pending.pop_front();
			if (got !== w) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp st%0d ev%0d k%h p%h pr%0d l%0d, ",
						"got st%0d ev%0d k%h p%h pr%0d l%0d"},
						w.status, w.evicted, w.okey, w.opay, w.present, w.last,
						got.status, got.evicted, got.okey, got.opay, got.present, got.last);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [39:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // key, obj_bytes, payload
	logic [2:0]   s_axis_tuser;   // kind
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;   // status, out_key, out_payload, zero fill
	logic [1:0]   m_axis_tuser;   // evicted, present
	logic         m_axis_tlast;

	cache_scoreboard sb;
	int  idle_cycles;
	bit  long_hold;

	lfu_size_budget_cache_policy #(.ENTRIES(NSLOT)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver: stall on its own pattern; a long hold-off when requested.
	initial begin
		int hold;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 0;
				hold = 400;
				repeat (hold) @(posedge clk);
				long_hold = 0;
			end
			case ($urandom_range(0, 3))
				0: m_axis_tready <= 0;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				default: m_axis_tready <= 1;
			endcase
		end
	end

	// Check each accepted result beat.
	always @(posedge clk) begin
		beat_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[2:0];
			got.okey = m_axis_tdata[34:3];
			got.opay = m_axis_tdata[98:35];
			got.evicted = m_axis_tuser[0];
			got.present = m_axis_tuser[1];
			got.last = m_axis_tlast;
			sb.check_beat(got);
		end
	end

	// Watchdog: count cycles with no beat moving on any channel.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("lfu_size_budget_cache_policy test failed");
				$finish;
			end
		end
	end

	// Send one op; hold tvalid until the block takes the beat.
	task automatic send_op(lfu_pkg::op_t op, bit [31:0] k, bit [31:0] osz, bit [63:0] p);
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {p, osz, k};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_op(op, k, osz, p);
	endtask

	task automatic gap();
		s_axis_tvalid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	// Wait for every expected beat, then let the sequencer settle.
	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_budget(bit [39:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.budget = v;
	endtask

	// Draw a key from a small pool so hits and repeats are common.
	function automatic bit [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF;
			2: return 32'h0;
			default: return 32'h100 + $urandom_range(0, 23);
		endcase
	endfunction

	// Random phase: bursts of mostly adds and hits, with random gaps.
	task automatic random_phase(int n, bit [31:0] size_max);
		int burst;
		lfu_pkg::op_t op;
		bit [63:0] p;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				gap();
				burst = $urandom_range(1, 12);
			end
			burst--;
			case ($urandom_range(0, 15))
				0, 1, 2, 3, 4: op = lfu_pkg::OP_ADD;
				5, 6, 7: op = lfu_pkg::OP_HIT;
				8: op = lfu_pkg::OP_HAS;
				9: op = lfu_pkg::OP_GET;
				10: op = lfu_pkg::OP_DEL;
				11: op = lfu_pkg::OP_PEEK;
				12: op = lfu_pkg::OP_SETPL;
				13: op = lfu_pkg::OP_NONE;
				default: op = lfu_pkg::OP_ADD;
			endcase
			p = {$urandom(), $urandom()};
			send_op(op, pick_key(), ($urandom_range(0, 7) == 0) ? $urandom() :
				$urandom_range(0, size_max), p);
		end
	endtask

	initial begin
		sb = new();
		idle_cycles = 0;
		long_hold = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = lfu_pkg::OP_NONE;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty peek, misses, extremes of fields, every op.
		send_op(lfu_pkg::OP_PEEK, 0, 0, 0);
		send_op(lfu_pkg::OP_HIT, 32'hDEAD, 0, 0);
		send_op(lfu_pkg::OP_GET, 32'hDEAD, 0, 0);
		send_op(lfu_pkg::OP_DEL, 32'hDEAD, 0, 0);
		send_op(lfu_pkg::OP_SETPL, 32'hDEAD, 0, 0);
		send_op(lfu_pkg::OP_NONE, '1, '1, '1);
		send_op(lfu_pkg::OP_ADD, 32'h0, 32'h0, 64'h0);          // zero-size object
		send_op(lfu_pkg::OP_ADD, '1, 32'h1000, '1);
		send_op(lfu_pkg::OP_ADD, '1, 32'h10, 64'h5);            // already present
		send_op(lfu_pkg::OP_ADD, 32'h55, '1, 64'h77);           // too big: not stored
		send_op(lfu_pkg::OP_ADD, 32'h1, 32'h100, 64'hAAAA_5555_AAAA_5555);
		send_op(lfu_pkg::OP_HIT, 32'h1, 0, 0);
		send_op(lfu_pkg::OP_HAS, 32'h1, 0, 0);
		send_op(lfu_pkg::OP_HAS, 32'h2, 0, 0);
		send_op(lfu_pkg::OP_GET, 32'h1, 0, 0);
		send_op(lfu_pkg::OP_SETPL, 32'h1, 0, 64'h5555_AAAA_5555_AAAA);
		send_op(lfu_pkg::OP_GET, 32'h1, 0, 0);
		send_op(lfu_pkg::OP_PEEK, 0, 0, 0);
		send_op(lfu_pkg::OP_DEL, 32'h1, 0, 0);
		// Fill past the table size to force full-table evictions.
		for (int i = 0; i < 18; i++) send_op(lfu_pkg::OP_ADD, 32'h200 + i, 32'h40, i);
		drain();

		// Tiny budget: lots of evictions per add.
		write_budget(40'h400);
		random_phase(40, 32'h200);
		drain();

		// Long receiver hold while the sender keeps offering.
		long_hold = 1;
		random_phase(15, 32'h100);
		drain();

		// Budget lowered to zero: next add flushes the whole table.
		write_budget(40'h0);
		send_op(lfu_pkg::OP_ADD, 32'h300, 0, 0);
		send_op(lfu_pkg::OP_PEEK, 0, 0, 0);
		drain();

		// Maximum budget, then default budget.
		write_budget('1);
		random_phase(45, 32'hFFFF_FFFF);
		drain();
		write_budget(lfu_pkg::DefaultLimit);
		random_phase(45, 32'h0400_0000);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("lfu_size_budget_cache_policy test passed");
		else
			$display("lfu_size_budget_cache_policy test failed");
		$finish;
	end
endmodule

// File: files.f
rtl/lfu_pkg.sv
rtl/lfu_size_budget_cache_policy.sv
tb/tb_lfu_size_budget_cache_policy.sv
